/* design/hid_report_descriptor_parser_macros.svh */
// Assertion macros for the report descriptor parser.
`ifndef HID_REPORT_DESCRIPTOR_PARSER_MACROS_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_MACROS_SVH
// Assert that a condition implies a property in the same cycle.
`define HRDP_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Assert that a condition implies a property in the next cycle.
`define HRDP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

/* design/hrdp_pkg.sv */
// ----------------------------------------------------------------------------
// hrdp_pkg
// Shared constants and types of the report descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none
package hrdp_pkg;
  localparam int MAX_USAGES_DEF       = 16;
  localparam int MAX_REPORT_COUNT_DEF = 64;

  localparam logic [5:0] TAG_END       = 6'h00;
  localparam logic [5:0] TAG_PAGE      = 6'h01;
  localparam logic [5:0] TAG_USAGE     = 6'h02;
  localparam logic [5:0] TAG_LOG_MIN   = 6'h05;
  localparam logic [5:0] TAG_LOG_MAX   = 6'h09;
  localparam logic [5:0] TAG_USAGE_MIN = 6'h06;
  localparam logic [5:0] TAG_USAGE_MAX = 6'h0A;
  localparam logic [5:0] TAG_SIZE      = 6'h1D;
  localparam logic [5:0] TAG_COUNT     = 6'h25;
  localparam logic [5:0] TAG_INPUT     = 6'h20;
  localparam logic [5:0] TAG_COLL      = 6'h28;
  localparam logic [5:0] TAG_END_COLL  = 6'h30;

  typedef enum logic [1:0] {
    RULE_SINGLE,
    RULE_LIST,
    RULE_RANGE,
    RULE_INDEX
  } rule_t;
endpackage
`default_nettype wire

/* design/hrdp_ram.sv */
// ----------------------------------------------------------------------------
// hrdp_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hrdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/hid_report_descriptor_parser.sv */
// Report descriptor parser. One descriptor byte is taken per beat, prefix and
// data bytes alike, and a byte waits while a result beat sits undelivered in
// the output register. An Input item emits one beat per report field. Each
// field first reads the usage list RAM and then loads the output register,
// waiting there while the output is backpressured. The input therefore stalls
// until the last field has been loaded. After a tag 0 prefix one end beat is
// sent and every later byte is accepted and dropped.
// ----------------------------------------------------------------------------
// hid_report_descriptor_parser
// Byte-serial HID report descriptor parser with a usage list memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hid_report_descriptor_parser_macros.svh"
module hid_report_descriptor_parser #(
  parameter int MAX_USAGES       = hrdp_pkg::MAX_USAGES_DEF,
  parameter int MAX_REPORT_COUNT = hrdp_pkg::MAX_REPORT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  desc_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [31:0]      usage,
  output logic [31:0]      usage_page,
  output logic [7:0]       field_size,
  output logic             is_signed,
  output logic             is_array,
  output logic             is_relative,
  output logic             discard,
  output logic [31:0]      logical_min,
  output logic [31:0]      logical_max,
  output logic [31:0]      total_bits,
  output logic             last
);
  localparam int AW = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
  localparam int RD = (MAX_USAGES > 1) ? MAX_USAGES : 2;
  localparam int FW = $clog2(MAX_USAGES + 1);
  localparam int CW = $clog2(MAX_REPORT_COUNT + 1);

  typedef enum logic [1:0] {S_PARSE, S_EMIT, S_DONE} state_t;

  state_t            state;
  logic              phase_data;
  logic [2:0]        bytes_left;
  logic [1:0]        byte_pos;
  logic [5:0]        item_tag;
  logic [31:0]       data_accum;
  logic [31:0]       cur_usage_page, log_min, log_max, usage_lo, usage_hi;
  logic [7:0]        size_bits;
  logic [CW-1:0]     field_count;
  logic [FW-1:0]     usage_fill;
  logic [31:0]       bit_total;
  hrdp_pkg::rule_t   rule;
  logic [CW-1:0]     idx;
  logic [2:0]        attr;
  logic              rd_pend;

  logic              item_go;
  logic [31:0]       item_data;
  logic [31:0]       word;
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;
  logic              slot_free;
  logic [31:0]       span;
  logic              beat_load;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_PARSE && slot_free) || state == S_DONE;
  assign beat_load = (state == S_PARSE && in_valid && in_ready && !phase_data &&
                      desc_byte[7:2] == hrdp_pkg::TAG_END) ||
                     (state == S_EMIT && rd_pend && slot_free);

  always_comb begin
    word = data_accum;
    unique case (byte_pos)
      2'd0: word[7:0]   = desc_byte;
      2'd1: word[15:8]  = desc_byte;
      2'd2: word[23:16] = desc_byte;
      default: word[31:24] = desc_byte;
    endcase
    item_go   = 1'b0;
    item_data = 32'd0;
    if (state == S_PARSE && in_valid && in_ready) begin
      if (!phase_data) begin
        item_go = desc_byte[7:2] != hrdp_pkg::TAG_END && desc_byte[1:0] == 2'd0;
      end else begin
        item_go   = bytes_left == 3'd1;
        item_data = word;
      end
    end
  end

  logic [5:0] tag_now;
  assign tag_now = phase_data ? item_tag : desc_byte[7:2];
  assign ram_we  = item_go && tag_now == hrdp_pkg::TAG_USAGE &&
                   usage_fill < FW'(MAX_USAGES);
  assign span    = usage_hi - usage_lo + 32'd1;
  assign ram_raddr = (rule == hrdp_pkg::RULE_SINGLE) ? AW'(0) : AW'(idx);

  hrdp_ram #(.WIDTH(32), .DEPTH(RD)) u_usages (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(usage_fill)),
    .wdata (item_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PARSE; phase_data <= 1'b0; bytes_left <= 3'd0; byte_pos <= 2'd0;
      item_tag <= '0; data_accum <= '0; cur_usage_page <= '0; log_min <= '0;
      log_max <= '0; usage_lo <= '0; usage_hi <= '0; size_bits <= '0;
      field_count <= '0; usage_fill <= '0; bit_total <= '0; out_valid <= 1'b0;
      rd_pend <= 1'b0; idx <= '0; rule <= hrdp_pkg::RULE_INDEX; attr <= '0;
    end else begin
      out_valid <= beat_load || (out_valid && !out_ready);
      unique case (state)
        S_PARSE: begin
          if (in_valid && in_ready) begin
            if (!phase_data) begin
              item_tag   <= desc_byte[7:2];
              data_accum <= '0;
              byte_pos   <= 2'd0;
              if (desc_byte[7:2] == hrdp_pkg::TAG_END) begin
                state <= S_DONE; kind <= 1'b1; usage <= '0;
                usage_page <= '0; field_size <= '0; is_signed <= 1'b0;
                is_array <= 1'b0; is_relative <= 1'b0; discard <= 1'b0;
                logical_min <= '0; logical_max <= '0; total_bits <= bit_total;
                last <= 1'b1;
              end else if (desc_byte[1:0] != 2'd0) begin
                phase_data <= 1'b1;
                bytes_left <= (desc_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, desc_byte[1:0]};
              end
            end else begin
              data_accum <= word;
              byte_pos   <= byte_pos + 2'd1;
              bytes_left <= bytes_left - 3'd1;
              if (bytes_left == 3'd1) phase_data <= 1'b0;
            end
          end
          if (item_go) begin
            unique case (tag_now)
              hrdp_pkg::TAG_PAGE:      cur_usage_page <= item_data;
              hrdp_pkg::TAG_USAGE:     if (ram_we) usage_fill <= usage_fill + FW'(1);
              hrdp_pkg::TAG_LOG_MIN:   log_min <= item_data;
              hrdp_pkg::TAG_LOG_MAX:   log_max <= item_data;
              hrdp_pkg::TAG_USAGE_MIN: usage_lo <= item_data;
              hrdp_pkg::TAG_USAGE_MAX: usage_hi <= item_data;
              hrdp_pkg::TAG_SIZE:
                size_bits <= (item_data > 32'd255) ? 8'hFF : item_data[7:0];
              hrdp_pkg::TAG_COUNT:
                field_count <= (item_data > 32'(MAX_REPORT_COUNT)) ?
                               CW'(MAX_REPORT_COUNT) : item_data[CW-1:0];
              hrdp_pkg::TAG_INPUT: begin
                attr <= item_data[2:0];
                idx  <= '0;
                rd_pend <= 1'b0;
                usage_fill <= '0;
                if (field_count != '0) state <= S_EMIT;
                priority if (usage_fill == FW'(1)) rule <= hrdp_pkg::RULE_SINGLE;
                else if (32'(usage_fill) == 32'(field_count)) rule <= hrdp_pkg::RULE_LIST;
                else if (usage_fill == '0 && span == 32'(field_count))
                  rule <= hrdp_pkg::RULE_RANGE;
                else rule <= hrdp_pkg::RULE_INDEX;
              end
              hrdp_pkg::TAG_COLL, hrdp_pkg::TAG_END_COLL: usage_fill <= '0;
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          // rd_pend: RAM data for idx is valid this cycle
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else if (slot_free) begin
            kind <= 1'b0; usage_page <= cur_usage_page;
            field_size <= size_bits; is_signed <= log_min > log_max;
            is_array <= !attr[1]; is_relative <= attr[2]; discard <= attr[0];
            logical_min <= log_min; logical_max <= log_max;
            total_bits <= bit_total + 32'(size_bits);
            bit_total  <= bit_total + 32'(size_bits);
            last <= idx + CW'(1) == field_count;
            unique case (rule)
              hrdp_pkg::RULE_SINGLE: usage <= ram_rdata;
              hrdp_pkg::RULE_LIST:
                usage <= (32'(idx) < 32'(MAX_USAGES)) ? ram_rdata : 32'd0;
              hrdp_pkg::RULE_RANGE: usage <= usage_lo + 32'(idx);
              default: usage <= 32'(idx);
            endcase
            rd_pend <= 1'b0;
            idx <= idx + CW'(1);
            if (idx + CW'(1) == field_count) state <= S_PARSE;
          end
        end
        default: ;
      endcase
    end
  end

  `HRDP_ASSERT_IMP(a_no_in_emit, state == S_EMIT, !in_ready)
  `HRDP_ASSERT_NEXT(a_done_stays, state == S_DONE, state == S_DONE)
  `HRDP_ASSERT_IMP(a_fill_cap, 1'b1, usage_fill <= FW'(MAX_USAGES))
endmodule
`default_nettype wire
